// ===== design/pdmfe_pkg.sv =====
// ----------------------------------------------------------------------------
// pdmfe_pkg: shared types and constants of the PDM-to-PCM audio front end
// Holds the configuration bundle, the queue entry, register indexes and the
// 16-bit saturation helper used by the back end.
// ----------------------------------------------------------------------------
package pdmfe_pkg;

	// PDM bits carried by one input word
	localparam int WORD_BITS = 16;

	// balance spans -256..256 over the whole decimation range
	localparam int BAL_W = 10;

	// |balance| * full scale stays below 2^23
	localparam int SCALE_MAG_W = 23;

	// entries in the queue between front and back
	localparam int QDEPTH = 2;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 15;

	localparam logic [CFG_IDX_W-1:0] CFG_HPF_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HPF_COEFF  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VOLUME     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_STEP  = 2'd3;

	// register reset values
	localparam logic        RST_HPF_ENABLE = 1'b1;
	localparam logic [14:0] RST_HPF_COEFF  = 15'd32604;
	localparam logic [6:0]  RST_VOLUME     = 7'd50;
	localparam logic [2:0]  RST_GAIN_STEP  = 3'd0;

	// gain exponent ceiling (times 16)
	localparam logic [2:0] GAIN_MAX_STEP = 3'd4;

	// divide by 100: magnitudes below 2^22, exact with this reciprocal
	localparam int          VOL_MAG_W   = 22;
	localparam int          VOL_SHIFT   = 29;
	localparam logic [22:0] VOL_RECIP   = 23'd5368710;

	// 16-bit PCM limits
	localparam logic signed [23:0] PCM_HI = 24'sd32767;
	localparam logic signed [23:0] PCM_LO = -24'sd32768;

	typedef struct packed {
		logic        hpf_enable;
		logic [14:0] hpf_coeff;
		logic [6:0]  volume;
		logic [2:0]  gain_step;
	} cfg_t;

	typedef struct packed {
		logic signed [BAL_W-1:0] balance;
		logic                    frame_last;
	} qent_t;

	typedef struct packed {
		logic               clip;
		logic signed [15:0] value;
	} sat_t;

	// clamp a signed value to 16 bits and flag when it had to
	function automatic sat_t sat16(input logic signed [23:0] v);
		sat_t r;
		if (v > PCM_HI) begin
			r.clip  = 1'b1;
			r.value = 16'sh7FFF;
		end else if (v < PCM_LO) begin
			r.clip  = 1'b1;
			r.value = -16'sh8000;
		end else begin
			r.clip  = 1'b0;
			r.value = v[15:0];
		end
		return r;
	endfunction

endpackage

// ===== design/pdmfe_front.sv =====
// ----------------------------------------------------------------------------
// pdmfe_front: PDM word intake and decimation bookkeeping
// Accepts one PDM word a cycle while the queue is not full, adds its bits to
// the running balance and, when the decimation window closes inside the word,
// pushes the finished balance with its frame flag into the queue.
// ----------------------------------------------------------------------------
module pdmfe_front #(
	parameter int DECIMATION    = 64,
	parameter int FRAME_SAMPLES = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [15:0]          pdm_bits,
	input  logic                 restart,
	input  logic                 q_full,
	output logic                 push,
	output pdmfe_pkg::qent_t     push_data
);

	localparam int PH_W   = $clog2(DECIMATION);
	localparam int NEED_W = PH_W + 1;
	localparam int FR_W   = (FRAME_SAMPLES > 1) ? $clog2(FRAME_SAMPLES) : 1;
	localparam int BW     = pdmfe_pkg::BAL_W;

	logic [PH_W-1:0]        phase_q;
	logic signed [BW-1:0]   balance_q;
	logic [FR_W-1:0]        frame_q;

	logic [PH_W-1:0]        ph;
	logic signed [BW-1:0]   bal;
	logic [FR_W-1:0]        fr;
	logic [NEED_W-1:0]      need;
	logic [NEED_W-1:0]      rest;
	logic [NEED_W-1:0]      ph_sum;
	logic                   done;
	logic [4:0]             ones_lo;
	logic [4:0]             ones_all;
	logic [4:0]             ones_hi;
	logic signed [BW-1:0]   bal_out;
	logic signed [BW-1:0]   bal_carry;
	logic signed [BW-1:0]   bal_acc;
	logic [FR_W:0]          fr_inc;
	logic                   last;
	logic                   accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// restart clears phase, balance and frame position ahead of this word
	assign ph  = restart ? '0 : phase_q;
	assign bal = restart ? '0 : balance_q;
	assign fr  = restart ? '0 : frame_q;

	// bits still missing from the current sample
	assign need = NEED_W'(DECIMATION) - {1'b0, ph};
	assign done = need <= NEED_W'(pdmfe_pkg::WORD_BITS);
	assign rest = NEED_W'(pdmfe_pkg::WORD_BITS) - need;
	assign ph_sum = {1'b0, ph} + NEED_W'(pdmfe_pkg::WORD_BITS);

	// ones below and above the window boundary
	always_comb begin
		ones_lo  = '0;
		ones_all = '0;
		for (int i = 0; i < pdmfe_pkg::WORD_BITS; i++) begin
			ones_all = ones_all + 5'(pdm_bits[i]);
			if (NEED_W'(i) < need)
				ones_lo = ones_lo + 5'(pdm_bits[i]);
		end
	end
	assign ones_hi = ones_all - ones_lo;

	// ones minus zeros = 2*ones - bits
	assign bal_out   = bal + $signed(BW'({ones_lo, 1'b0})) - $signed(BW'(need));
	assign bal_carry = $signed(BW'({ones_hi, 1'b0})) - $signed(BW'(rest));
	assign bal_acc   = bal + $signed(BW'({ones_all, 1'b0}))
		- $signed(BW'(pdmfe_pkg::WORD_BITS));

	// frame position
	assign fr_inc = {1'b0, fr} + (FR_W+1)'(1);
	assign last   = fr_inc >= (FR_W+1)'(FRAME_SAMPLES);

	assign push                 = accept && done;
	assign push_data.balance    = bal_out;
	assign push_data.frame_last = last;

	// decimation state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= '0;
			balance_q <= '0;
			frame_q   <= '0;
		end else if (accept) begin
			if (done) begin
				phase_q   <= rest[PH_W-1:0];
				balance_q <= bal_carry;
				frame_q   <= last ? '0 : fr_inc[FR_W-1:0];
			end else begin
				phase_q   <= ph_sum[PH_W-1:0];
				balance_q <= bal_acc;
				frame_q   <= fr;
			end
		end
	end

`ifndef ASSERT_OFF
	// phase never reaches the window length
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, phase_q} < NEED_W'(DECIMATION))
		else $error("decimation phase out of range");
`endif

endmodule

// ===== design/pdmfe_queue.sv =====
// ----------------------------------------------------------------------------
// pdmfe_queue: short queue between front and back
// Holds finished balances so that intake and sample processing stall apart.
// ----------------------------------------------------------------------------
module pdmfe_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  pdmfe_pkg::qent_t     push_data,
	output logic                 full,
	input  logic                 pop,
	output logic                 head_valid,
	output pdmfe_pkg::qent_t     head_data
);

	localparam int PTR_W = $clog2(pdmfe_pkg::QDEPTH);
	localparam int CNT_W = $clog2(pdmfe_pkg::QDEPTH + 1);

	pdmfe_pkg::qent_t  entry_q [pdmfe_pkg::QDEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign full       = count_q == CNT_W'(pdmfe_pkg::QDEPTH);
	assign head_valid = count_q != '0;
	assign head_data  = entry_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// storage
	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_ptr_q] <= push_data;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(pdmfe_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(pdmfe_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

`ifndef ASSERT_OFF
	// the front never offers a beat the queue cannot hold
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

	// fill level stays within depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(pdmfe_pkg::QDEPTH))
		else $error("queue count out of range");
`endif

endmodule

// ===== design/pdmfe_back.sv =====
// ----------------------------------------------------------------------------
// pdmfe_back: sample processing pipeline
// Scales a balance to PCM, runs the DC-blocking high-pass, volume and gain,
// and holds the result in an output register. The whole pipeline advances
// together whenever the output register is free or being drained.
// ----------------------------------------------------------------------------
module pdmfe_back #(
	parameter int DECIMATION     = 64,
	parameter int PCM_FULL_SCALE = 32767
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pdmfe_pkg::cfg_t      cfg,
	input  logic                 head_valid,
	input  pdmfe_pkg::qent_t     head_data,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [15:0]   pcm_sample,
	output logic                 clipped,
	output logic                 frame_last
);

	localparam int MAG_W   = pdmfe_pkg::SCALE_MAG_W;
	localparam int SHIFT   = MAG_W + $clog2(DECIMATION);
	localparam int RECIP_W = 25;
	localparam longint unsigned RECIP_FULL =
		((64'd1 << SHIFT) + 64'(DECIMATION) - 64'd1) / 64'(DECIMATION);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
	localparam logic [14:0]        FULL_SCALE = 15'(PCM_FULL_SCALE);
	localparam int VW = pdmfe_pkg::VOL_MAG_W;

	logic advance;

	// stage 1: |balance| * full scale
	logic               valid_s1;
	logic [MAG_W-1:0]   mag_s1;
	logic               neg_s1;
	logic               last_s1;
	logic signed [pdmfe_pkg::BAL_W-1:0] bal_abs;
	logic [23:0]        mag_full;

	// stage 2: divide by decimation
	logic               valid_s2;
	logic signed [15:0] x_s2;
	logic               last_s2;
	logic [MAG_W+RECIP_W-1:0] div_prod;
	logic [15:0]        div_q;

	// stage 3: high-pass
	logic               valid_s3;
	logic signed [15:0] x_s3;
	logic               clip_s3;
	logic               last_s3;
	logic signed [15:0] xp_q;
	logic signed [15:0] yp_q;
	logic signed [17:0] hp_sum;
	logic signed [33:0] hp_prod;
	logic signed [33:0] hp_shift;
	pdmfe_pkg::sat_t    hp_sat;

	// stage 4: times volume
	logic               valid_s4;
	logic [VW-1:0]      vmag_s4;
	logic               vneg_s4;
	logic               clip_s4;
	logic               last_s4;
	logic signed [23:0] vol_prod;
	logic signed [23:0] vol_abs;

	// stage 5: divide by 100
	logic               valid_s5;
	logic signed [15:0] x_s5;
	logic               clip_s5;
	logic               last_s5;
	logic [VW+22:0]     vdiv_prod;
	logic [15:0]        vdiv_q;
	logic signed [23:0] vdiv_s;
	pdmfe_pkg::sat_t    vol_sat;

	// output: gain
	logic               out_valid_q;
	logic signed [15:0] sample_q;
	logic               clip_q;
	logic               last_q;
	logic [2:0]         gain;
	logic signed [23:0] gain_val;
	pdmfe_pkg::sat_t    gain_sat;

	assign advance = !out_valid_q || out_ready;
	assign pop     = advance && head_valid;

	// stage 1 math
	assign bal_abs  = head_data.balance[pdmfe_pkg::BAL_W-1] ?
		-head_data.balance : head_data.balance;
	assign mag_full = bal_abs[8:0] * FULL_SCALE;

	// stage 2 math: exact reciprocal divide
	assign div_prod = mag_s1 * RECIP;
	assign div_q    = 16'(div_prod >> SHIFT);

	// stage 3 math: y = trunc((x - xp + yp) * coeff / 32768)
	assign hp_sum   = 18'(x_s2) - 18'(xp_q) + 18'(yp_q);
	assign hp_prod  = 34'(hp_sum) * $signed({19'd0, cfg.hpf_coeff});
	assign hp_shift = hp_prod[33] ? ((hp_prod + 34'sd32767) >>> 15) : (hp_prod >>> 15);
	assign hp_sat   = pdmfe_pkg::sat16(hp_shift[23:0]);

	// stage 4 math
	assign vol_prod = 24'(x_s3) * $signed({17'd0, cfg.volume});
	assign vol_abs  = vol_prod[23] ? -vol_prod : vol_prod;

	// stage 5 math
	assign vdiv_prod = vmag_s4 * pdmfe_pkg::VOL_RECIP;
	assign vdiv_q    = 16'(vdiv_prod >> pdmfe_pkg::VOL_SHIFT);
	assign vdiv_s    = vneg_s4 ? -$signed({8'd0, vdiv_q}) : $signed({8'd0, vdiv_q});
	assign vol_sat   = pdmfe_pkg::sat16(vdiv_s);

	// gain math
	assign gain     = (cfg.gain_step > pdmfe_pkg::GAIN_MAX_STEP) ?
		pdmfe_pkg::GAIN_MAX_STEP : cfg.gain_step;
	assign gain_val = 24'(x_s5) <<< gain;
	assign gain_sat = pdmfe_pkg::sat16(gain_val);

	// stage valid bits and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			valid_s5    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= head_valid;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			valid_s4    <= valid_s3;
			valid_s5    <= valid_s4;
			out_valid_q <= valid_s5;
		end
	end

	// high-pass history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xp_q <= '0;
			yp_q <= '0;
		end else if (advance && valid_s2 && cfg.hpf_enable) begin
			xp_q <= x_s2;
			yp_q <= hp_sat.value;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (advance) begin
			mag_s1  <= mag_full[MAG_W-1:0];
			neg_s1  <= head_data.balance[pdmfe_pkg::BAL_W-1];
			last_s1 <= head_data.frame_last;

			x_s2    <= neg_s1 ? -$signed(div_q) : $signed(div_q);
			last_s2 <= last_s1;

			if (cfg.hpf_enable) begin
				x_s3    <= hp_sat.value;
				clip_s3 <= hp_sat.clip;
			end else begin
				x_s3    <= x_s2;
				clip_s3 <= 1'b0;
			end
			last_s3 <= last_s2;

			vmag_s4 <= vol_abs[VW-1:0];
			vneg_s4 <= vol_prod[23];
			clip_s4 <= clip_s3;
			last_s4 <= last_s3;

			x_s5    <= vol_sat.value;
			clip_s5 <= clip_s4 | vol_sat.clip;
			last_s5 <= last_s4;

			sample_q <= gain_sat.value;
			clip_q   <= clip_s5 | gain_sat.clip;
			last_q   <= last_s5;
		end
	end

	assign out_valid  = out_valid_q;
	assign pcm_sample = sample_q;
	assign clipped    = clip_q;
	assign frame_last = last_q;

`ifndef ASSERT_OFF
	// a result appears only from a filled last stage
	a_out_from_s5: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s5))
		else $error("output loaded without a sample");

	// bypassed filter keeps its history
	a_hpf_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg.hpf_enable |=> $stable(xp_q) && $stable(yp_q))
		else $error("filter history moved while bypassed");

	// a stalled output stalls the whole pipeline
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !pop)
		else $error("queue popped while output stalled");
`endif

endmodule

// ===== design/pdm_to_pcm_audio_frontend.sv =====
// ----------------------------------------------------------------------------
// pdm_to_pcm_audio_frontend: PDM decimator with DC-blocking high-pass
// Turns PDM words into 16-bit PCM samples, then applies high-pass, volume and
// power-of-two gain, flagging clipping and the end of each frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one beat is a 16-bit PDM word, bit 0
//   oldest, plus restart, which realigns decimation and frame position
//   before that word. Every DECIMATION bits produce one sample.
//   Output channel (out_valid/out_ready): one beat per finished sample with
//   pcm_sample, clipped and frame_last.
//   Config channel (cfg_valid/cfg_ready): cfg_index selects hpf_enable,
//   hpf_coeff, volume or gain_step; cfg_ready is always high. Write only
//   while no sample is in flight.
//   Throughput: one PDM word per cycle; the back-end pipeline finishes one
//   sample per cycle, so intake only stalls when the receiver does.
//   Path: a sample completed by an accepted word is written to the queue, then
//   passes five pipeline stages and the output register before it is presented.
//   Stalls: a held output freezes the pipeline; the two-entry queue then
//   fills and in_ready drops.
//   Reset: clears decimation, frame and filter state and loads the register
//   defaults (filter on, coeff 32604, volume 50, gain 0).
// ----------------------------------------------------------------------------
module pdm_to_pcm_audio_frontend #(
	parameter int DECIMATION     = 64,
	parameter int FRAME_SAMPLES  = 256,
	parameter int PCM_FULL_SCALE = 32767
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [15:0]                         pdm_bits,
	input  logic                                restart,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [15:0]                  pcm_sample,
	output logic                                clipped,
	output logic                                frame_last,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pdmfe_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pdmfe_pkg::CFG_DATA_W-1:0]    cfg_data
);

	pdmfe_pkg::cfg_t   cfg_q;
	pdmfe_pkg::qent_t  push_data;
	pdmfe_pkg::qent_t  head_data;
	logic              push;
	logic              q_full;
	logic              pop;
	logic              head_valid;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hpf_enable <= pdmfe_pkg::RST_HPF_ENABLE;
			cfg_q.hpf_coeff  <= pdmfe_pkg::RST_HPF_COEFF;
			cfg_q.volume     <= pdmfe_pkg::RST_VOLUME;
			cfg_q.gain_step  <= pdmfe_pkg::RST_GAIN_STEP;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pdmfe_pkg::CFG_HPF_ENABLE: cfg_q.hpf_enable <= cfg_data[0];
				pdmfe_pkg::CFG_HPF_COEFF:  cfg_q.hpf_coeff  <= cfg_data[14:0];
				pdmfe_pkg::CFG_VOLUME:     cfg_q.volume     <= cfg_data[6:0];
				pdmfe_pkg::CFG_GAIN_STEP:  cfg_q.gain_step  <= cfg_data[2:0];
				default: begin
				end
			endcase
		end
	end

	pdmfe_front #(
		.DECIMATION    (DECIMATION),
		.FRAME_SAMPLES (FRAME_SAMPLES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pdm_bits  (pdm_bits),
		.restart   (restart),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	pdmfe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	pdmfe_back #(
		.DECIMATION     (DECIMATION),
		.PCM_FULL_SCALE (PCM_FULL_SCALE)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pcm_sample (pcm_sample),
		.clipped    (clipped),
		.frame_last (frame_last)
	);

endmodule
